// ===== hw/rtl/abt_pkg.sv =====
// Shared types and constants for the address breakpoint table.
package abt_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXISTS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] address;
    logic [7:0]  handler_tag;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic [5:0] slot_index;
    logic [7:0] hit_tag;
    logic [6:0] active_count;
  } rsp_t;

  // Request as it travels down the row of slots, with what it has found so far.
  typedef struct packed {
    logic             valid;
    logic [2:0]       opcode;
    logic [31:0]      address;
    logic [7:0]       handler_tag;
    logic             found;
    logic             placed;
    logic [IDX_W-1:0] idx;
    logic [7:0]       htag;
  } carry_t;

endpackage

// ===== hw/rtl/abt_cell.sv =====
// One breakpoint slot: holds address, tag, active and used bits, passes the request on.
module abt_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [abt_pkg::IDX_W-1:0] slot_id,
  input  abt_pkg::carry_t          carry_in,
  output abt_pkg::carry_t          carry_out
);

  logic [31:0]     addr_r;
  logic [7:0]      tag_r;
  logic            active_r, active_nxt;
  logic            used_r, used_nxt;
  logic            wr_en;
  logic            match;
  abt_pkg::carry_t carry_r, carry_nxt;

  assign match = active_r && (addr_r == carry_in.address) && !carry_in.found;

  always_comb begin
    carry_nxt  = carry_in;
    active_nxt = active_r;
    used_nxt   = used_r;
    wr_en      = 1'b0;
    if (carry_in.valid) begin
      case (carry_in.opcode)
        abt_pkg::OP_LOOKUP: begin
          if (match) begin
            carry_nxt.found = 1'b1;
            carry_nxt.idx   = slot_id;
            carry_nxt.htag  = tag_r;
          end
        end
        abt_pkg::OP_ADD: begin
          if (match) begin
            carry_nxt.found = 1'b1;
          end else if (!used_r && !carry_in.placed && !carry_in.found) begin
            wr_en            = 1'b1;
            active_nxt       = 1'b1;
            used_nxt         = 1'b1;
            carry_nxt.placed = 1'b1;
            carry_nxt.idx    = slot_id;
          end
        end
        abt_pkg::OP_DELETE: begin
          if (match) begin
            carry_nxt.found = 1'b1;
            active_nxt      = 1'b0;
          end
        end
        abt_pkg::OP_CLEAR: begin
          active_nxt = 1'b0;
          used_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      used_r   <= 1'b0;
      carry_r  <= '0;
    end else begin
      active_r <= active_nxt;
      used_r   <= used_nxt;
      carry_r  <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_r <= carry_in.address;
      tag_r  <= carry_in.handler_tag;
    end
  end

  assign carry_out = carry_r;

endmodule

// ===== hw/rtl/abt_ctrl.sv =====
// Request intake, result formation, active count and output buffering.
module abt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  abt_pkg::req_t   in_req,
  output logic            out_valid,
  input  logic            out_ready,
  output abt_pkg::rsp_t   out_rsp,
  output abt_pkg::carry_t head,
  input  abt_pkg::carry_t tail
);

  abt_pkg::carry_t           head_r;
  logic                      busy_r;
  logic [abt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  abt_pkg::rsp_t             out_r, hold_r, rsp;
  logic                      out_v_r, hold_v_r;
  logic                      accept;

  assign in_ready = !busy_r && !hold_v_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    rsp            = '0;
    cnt_nxt        = cnt_r;
    case (tail.opcode)
      abt_pkg::OP_LOOKUP: begin
        if (tail.found) begin
          rsp.hit        = 1'b1;
          rsp.slot_index = 6'(tail.idx);
          rsp.hit_tag    = tail.htag;
        end else begin
          rsp.status = abt_pkg::ST_NOTFOUND;
        end
      end
      abt_pkg::OP_ADD: begin
        if (tail.found) begin
          rsp.status = abt_pkg::ST_EXISTS;
        end else if (!tail.placed) begin
          rsp.status = abt_pkg::ST_FULL;
        end else begin
          rsp.slot_index = 6'(tail.idx);
          cnt_nxt        = cnt_r + abt_pkg::CNT_W'(1);
        end
      end
      abt_pkg::OP_DELETE: begin
        if (tail.found) begin
          cnt_nxt = cnt_r - abt_pkg::CNT_W'(1);
        end else begin
          rsp.status = abt_pkg::ST_NOTFOUND;
        end
      end
      abt_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase
    rsp.active_count = 7'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      head_r.valid <= accept;
      if (accept) begin
        head_r.opcode      <= in_req.opcode;
        head_r.address     <= in_req.address;
        head_r.handler_tag <= in_req.handler_tag;
        head_r.found       <= 1'b0;
        head_r.placed      <= 1'b0;
        head_r.idx         <= '0;
        head_r.htag        <= '0;
        busy_r             <= 1'b1;
      end
      if (tail.valid) begin
        busy_r <= 1'b0;
        cnt_r  <= cnt_nxt;
        if (!out_v_r || out_ready) begin
          out_r   <= rsp;
          out_v_r <= 1'b1;
        end else begin
          hold_r   <= rsp;
          hold_v_r <= 1'b1;
        end
      end else if (out_v_r && out_ready) begin
        if (hold_v_r) begin
          out_r    <= hold_r;
          hold_v_r <= 1'b0;
        end else begin
          out_v_r <= 1'b0;
        end
      end
    end
  end

  assign head      = head_r;
  assign out_valid = out_v_r;
  assign out_rsp   = out_r;

endmodule

// ===== hw/rtl/address_breakpoint_table.sv =====
// Address breakpoint table top level: control plus a row of slot cells.
//
// A request is taken when in_ready is high, enters the row of SLOTS slot
// cells one register past the input and moves one cell per clock; each cell
// compares, claims, fills or clears its own slot as the request passes. The
// result is registered at the output once the request leaves the last cell,
// and only then is the next request taken, so a request does not enter the
// row before the last one is through. A finished result waits in the
// output register while the next request runs; if that one finishes before
// the first is taken, it waits in a holding register and input stalls until
// the output drains. Lookup, add and delete match only active slots; adds
// fill slots in order and deleted slots are reused only after a clear. Every
// result carries the active slot count.
module address_breakpoint_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  abt_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output abt_pkg::rsp_t out_rsp
);

  abt_pkg::carry_t chain [abt_pkg::SLOTS+1];

  abt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .head      (chain[0]),
    .tail      (chain[abt_pkg::SLOTS])
  );

  for (genvar i = 0; i < abt_pkg::SLOTS; i++) begin : g_slot
    abt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .slot_id   (abt_pkg::IDX_W'(i)),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1])
    );
  end

endmodule

// ===== hw/rtl/abt_checker.sv =====
// Port-level checks for the breakpoint table, bound to the top level.
module abt_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input abt_pkg::rsp_t out_rsp
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.active_count <= 7'(abt_pkg::SLOTS))
    else $error("active count above table size");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.hit |-> out_rsp.status == abt_pkg::ST_OK)
    else $error("hit with non-ok status");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != abt_pkg::ST_OK
      |-> !out_rsp.hit && out_rsp.hit_tag == 8'd0 && out_rsp.slot_index == 6'd0)
    else $error("failed request reports slot data");

endmodule

bind address_breakpoint_table abt_checker u_abt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);
